[hdl/colormap_alpha_blend_macros.svh]
// assertion helpers for colormap_alpha_blend, the block that checks itself
`ifndef COLORMAP_ALPHA_BLEND_MACROS_SVH
`define COLORMAP_ALPHA_BLEND_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cab_pkg.sv]
`default_nettype none

package cab_pkg;

  localparam int unsigned TableDepthDefault = 256;

  localparam logic FuncPixel      = 1'b0;
  localparam logic FuncTableWrite = 1'b1;

  typedef enum logic [1:0] {
    RegRangeMin      = 2'd0,
    RegIndexScale    = 2'd1,
    RegBinCount      = 2'd2,
    RegOverwriteMode = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               func;
    logic signed [31:0] value;
    logic               value_invalid;
    logic [7:0]         dest_red;
    logic [7:0]         dest_green;
    logic [7:0]         dest_blue;
    logic [7:0]         entry_index;
    logic [7:0]         entry_red;
    logic [7:0]         entry_green;
    logic [7:0]         entry_blue;
    logic [7:0]         entry_alpha;
  } cab_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       updated;
  } cab_out_t;

endpackage

`default_nettype wire

[hdl/cab_if.sv]
`default_nettype none

interface cab_in_if;
  import cab_pkg::*;
  logic    valid;
  logic    ready;
  cab_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cab_out_if;
  import cab_pkg::*;
  logic     valid;
  logic     ready;
  cab_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/cab_ram.sv]
`default_nettype none

module cab_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/colormap_alpha_blend.sv]
`default_nettype none
// channel   dir  kind          word
// pix_i     in   valid/ready   cab_in_t: pixel to map or table entry write
// res_o     out  valid/ready   cab_out_t: one per pixel, none per table write
// apb       in   psel/penable  range_min, index_scale, bin_count, overwrite_mode
//
// one word per cycle sustained while res_o is ready
// stages: offset subtract, 32x32 scale multiply, clamp + table read, blend multiply,
// divide by 255 into the output register
// reset clears valid bits and sets config registers to their defaults; table contents undefined until written
// each stage moves when the one after it is empty or moving, so bubbles fill under stall

module colormap_alpha_blend #(
  parameter int unsigned TableDepth = cab_pkg::TableDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  cab_in_if.sink           pix_i,
  cab_out_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import cab_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned BinW  = (CntW > 9) ? CntW : 9;

  // configuration registers
  logic signed [31:0] range_min_q;
  logic [31:0]        index_scale_q;
  logic [8:0]         bin_count_q;
  logic               overwrite_mode_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q      <= '0;
      index_scale_q    <= 32'd65536;
      bin_count_q      <= 9'd256;
      overwrite_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        RegRangeMin:      range_min_q      <= pwdata;
        RegIndexScale:    index_scale_q    <= pwdata;
        RegBinCount:      bin_count_q      <= pwdata[8:0];
        RegOverwriteMode: overwrite_mode_q <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegRangeMin:      prdata = range_min_q;
      RegIndexScale:    prdata = index_scale_q;
      RegBinCount:      prdata = {23'd0, bin_count_q};
      RegOverwriteMode: prdata = {31'd0, overwrite_mode_q};
    endcase
  end

  // bins in use, held to 1..TableDepth
  logic [BinW-1:0] bins_eff;
  always_comb begin
    if (bin_count_q == 9'd0) begin
      bins_eff = BinW'(1);
    end else if (BinW'(bin_count_q) > BinW'(TableDepth)) begin
      bins_eff = BinW'(TableDepth);
    end else begin
      bins_eff = BinW'(bin_count_q);
    end
  end

  // stage enables, back to front
  logic en1, en2, en3, en4, en5;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, res_v_q;

  assign en5 = !res_v_q || res_o.ready;
  assign en4 = !s4_v_q || en5;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;

  assign pix_i.ready = en1;

  // stage 1: offset from range_min
  logic               s1_func_q, s1_inv_q;
  logic [23:0]        s1_dest_q;
  logic [7:0]         s1_eidx_q;
  logic [31:0]        s1_ent_q;
  logic signed [32:0] s1_diff_q;
  logic signed [32:0] diff_d;

  assign diff_d = {pix_i.data.value[31], pix_i.data.value} - {range_min_q[31], range_min_q};

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_func_q <= pix_i.data.func;
      s1_inv_q  <= pix_i.data.value_invalid;
      s1_dest_q <= {pix_i.data.dest_blue, pix_i.data.dest_green, pix_i.data.dest_red};
      s1_eidx_q <= pix_i.data.entry_index;
      s1_ent_q  <= {pix_i.data.entry_alpha, pix_i.data.entry_blue,
                    pix_i.data.entry_green, pix_i.data.entry_red};
      s1_diff_q <= diff_d;
    end
  end

  // stage 2: scale, keep the integer part of the Q32 product
  logic        s2_func_q, s2_inv_q, s2_le0_q;
  logic [23:0] s2_dest_q;
  logic [7:0]  s2_eidx_q;
  logic [31:0] s2_ent_q;
  logic [31:0] s2_idx_hi_q;
  logic [63:0] prod_d;

  assign prod_d = 64'(s1_diff_q[31:0]) * 64'(index_scale_q);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_func_q   <= s1_func_q;
      s2_inv_q    <= s1_inv_q;
      s2_le0_q    <= s1_diff_q[32] || (s1_diff_q == '0);
      s2_dest_q   <= s1_dest_q;
      s2_eidx_q   <= s1_eidx_q;
      s2_ent_q    <= s1_ent_q;
      s2_idx_hi_q <= prod_d[63:32];
    end
  end

  // clamp and table access: writes and reads share one port in program order
  logic [AddrW-1:0] rd_idx;
  logic [AddrW-1:0] ram_addr;
  logic             s2_is_wr;
  logic             ram_we;
  logic [31:0]      ram_rdata;

  always_comb begin
    if (s2_le0_q) begin
      rd_idx = '0;
    end else if (s2_idx_hi_q >= 32'(bins_eff)) begin
      rd_idx = AddrW'(bins_eff - BinW'(1));
    end else begin
      rd_idx = AddrW'(s2_idx_hi_q);
    end
  end

  assign s2_is_wr = (s2_func_q == FuncTableWrite);
  assign ram_we   = s2_v_q && s2_is_wr && (32'(s2_eidx_q) < 32'(TableDepth)) && en3;
  assign ram_addr = s2_is_wr ? AddrW'(s2_eidx_q) : rd_idx;

  cab_ram #(
    .Width (32),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (en3),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (s2_ent_q),
    .rdata_o (ram_rdata)
  );

  // stage 3: entry available, only pixels remain
  logic        s3_inv_q;
  logic [23:0] s3_dest_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_inv_q  <= s2_inv_q;
      s3_dest_q <= s2_dest_q;
    end
  end

  // stage 4: blend numerators dest*(255-a) + c*a
  logic        s4_inv_q;
  logic [23:0] s4_dest_q;
  logic [31:0] s4_ent_q;
  logic [15:0] s4_num_q [3];
  logic [15:0] num_d [3];
  logic [7:0]  alpha;
  logic [7:0]  alpha_inv;

  assign alpha     = ram_rdata[31:24];
  assign alpha_inv = 8'd255 - alpha;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_d[c] = 16'(s3_dest_q[8*c +: 8]) * 16'(alpha_inv)
               + 16'(ram_rdata[8*c +: 8]) * 16'(alpha);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_inv_q  <= s3_inv_q;
      s4_dest_q <= s3_dest_q;
      s4_ent_q  <= ram_rdata;
      for (int c = 0; c < 3; c++) begin
        s4_num_q[c] <= num_d[c];
      end
    end
  end

  // stage 5: divide by 255, exact for numerators up to 255*255
  logic [7:0] quot [3];
  logic [16:0] quot_t [3];
  cab_out_t   res_d;
  cab_out_t   res_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quot_t[c] = 17'(s4_num_q[c]) + 17'(s4_num_q[c][15:8]) + 17'd1;
      quot[c]   = quot_t[c][15:8];
    end
  end

  always_comb begin
    if (s4_inv_q) begin
      res_d.out_red   = s4_dest_q[7:0];
      res_d.out_green = s4_dest_q[15:8];
      res_d.out_blue  = s4_dest_q[23:16];
      res_d.out_alpha = 8'd0;
      res_d.updated   = 1'b0;
    end else if (overwrite_mode_q) begin
      res_d.out_red   = s4_ent_q[7:0];
      res_d.out_green = s4_ent_q[15:8];
      res_d.out_blue  = s4_ent_q[23:16];
      res_d.out_alpha = s4_ent_q[31:24];
      res_d.updated   = 1'b1;
    end else begin
      res_d.out_red   = quot[0];
      res_d.out_green = quot[1];
      res_d.out_blue  = quot[2];
      res_d.out_alpha = 8'd0;
      res_d.updated   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      res_q <= res_d;
    end
  end

  // valid bits; table writes drop out after the table access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= pix_i.valid;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q && !s2_is_wr;
      end
      if (en4) begin
        s4_v_q <= s3_v_q;
      end
      if (en5) begin
        res_v_q <= s4_v_q;
      end
    end
  end

  assign res_o.valid = res_v_q;
  assign res_o.data  = res_q;

`include "colormap_alpha_blend_macros.svh"

  `CAB_ASSERT_NXT(a_wr_no_result, s2_v_q && s2_is_wr && en3, !s3_v_q, "table write left a word")
  `CAB_ASSERT_IMP(a_idx_in_bins, s2_v_q && !s2_is_wr, 32'(rd_idx) < 32'(bins_eff), "index past bins")
  `CAB_ASSERT_NXT(a_s4_hold, s4_v_q && !en4, s4_v_q && $stable(s4_ent_q), "stalled word changed")

endmodule

`default_nettype wire
